FILE: rtl/core/kbsr_pkg.sv
// ----------------------------------------------------------------------------
// kbsr_pkg
// Shared types, register codes and key translation tables for the keyboard
// scan report builder.
// ----------------------------------------------------------------------------
`default_nettype none

package kbsr_pkg;

   localparam int KEY_W     = 8;
   localparam int CODE_W    = 8;
   localparam int MOD_W     = 8;
   localparam int OUT_SLOTS = 6;

   // configuration register indexes
   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_LAYOUT = 1'b1;

   localparam logic [1:0] LAYOUT_QWERTY = 2'd0;
   localparam logic [1:0] LAYOUT_AZERTY = 2'd1;

   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] addr;
   } map_rd_type;

   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] addr;
      logic             data;
   } map_wr_type;

   typedef struct packed {
      logic [MOD_W-1:0]                 mods;
      logic [OUT_SLOTS-1:0][CODE_W-1:0] codes;
   } report_type;

   // entries the two layouts have in common
   function automatic logic [CODE_W-1:0] common_code(input logic [KEY_W-1:0] key);
      logic [CODE_W-1:0] code;
      code = '0;
      if (key >= 8'd49 && key <= 8'd57)
         code = key - 8'd19;
      else if (key >= 8'd97 && key <= 8'd105)
         code = key - 8'd8;
      else if (key >= 8'd112 && key <= 8'd123)
         code = key - 8'd54;
      else begin
         unique case (key)
            8'd8:    code = 8'h2A;
            8'd9:    code = 8'h2B;
            8'd13:   code = 8'h28;
            8'd19:   code = 8'h48;
            8'd20:   code = 8'h39;
            8'd27:   code = 8'h29;
            8'd32:   code = 8'h2C;
            8'd33:   code = 8'h4B;
            8'd34:   code = 8'h4E;
            8'd35:   code = 8'h4D;
            8'd36:   code = 8'h4A;
            8'd37:   code = 8'h50;
            8'd38:   code = 8'h52;
            8'd39:   code = 8'h4F;
            8'd40:   code = 8'h51;
            8'd44:   code = 8'h46;
            8'd45:   code = 8'h49;
            8'd46:   code = 8'h4C;
            8'd48:   code = 8'h27;
            8'd96:   code = 8'h62;
            8'd106:  code = 8'h55;
            8'd107:  code = 8'h57;
            8'd109:  code = 8'h56;
            8'd110:  code = 8'h63;
            8'd111:  code = 8'h54;
            8'd144:  code = 8'h53;
            8'd145:  code = 8'h47;
            default: code = '0;
         endcase
      end
      return code;
   endfunction

   function automatic logic [CODE_W-1:0] qwerty_code(input logic [KEY_W-1:0] key);
      logic [CODE_W-1:0] code;
      code = common_code(key);
      if (key >= 8'd65 && key <= 8'd90)
         code = key - 8'd61;
      else begin
         unique case (key)
            8'd186:  code = 8'h33;
            8'd187:  code = 8'h2E;
            8'd188:  code = 8'h36;
            8'd189:  code = 8'h2D;
            8'd190:  code = 8'h37;
            8'd191:  code = 8'h38;
            8'd192:  code = 8'h35;
            8'd219:  code = 8'h2F;
            8'd220:  code = 8'h32;
            8'd221:  code = 8'h30;
            8'd222:  code = 8'h34;
            default: ;
         endcase
      end
      return code;
   endfunction

   function automatic logic [CODE_W-1:0] azerty_code(input logic [KEY_W-1:0] key);
      logic [CODE_W-1:0] code;
      code = common_code(key);
      if (key >= 8'd65 && key <= 8'd90) begin
         unique case (key)
            8'd65:   code = 8'h14;
            8'd77:   code = 8'h33;
            8'd81:   code = 8'h04;
            8'd87:   code = 8'h1D;
            8'd90:   code = 8'h1A;
            default: code = key - 8'd61;
         endcase
      end else begin
         unique case (key)
            8'd186:  code = 8'h30;
            8'd187:  code = 8'h2E;
            8'd188:  code = 8'h10;
            8'd190:  code = 8'h36;
            8'd191:  code = 8'h37;
            8'd192:  code = 8'h34;
            8'd219:  code = 8'h2D;
            8'd220:  code = 8'h32;
            8'd221:  code = 8'h2F;
            8'd223:  code = 8'h38;
            default: ;
         endcase
      end
      return code;
   endfunction

   function automatic logic [CODE_W-1:0] translate(input logic [1:0]       layout,
                                                   input logic [KEY_W-1:0] key);
      logic [CODE_W-1:0] code;
      unique case (layout)
         LAYOUT_QWERTY: code = qwerty_code(key);
         LAYOUT_AZERTY: code = azerty_code(key);
         default:       code = '0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/kbsr_map_ram.sv
// ----------------------------------------------------------------------------
// kbsr_map_ram
// Key down-map: 1-bit synchronous RAM with registered read and per-entry
// valid bits so the map reads as all up right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsr_map_ram
   import kbsr_pkg::*;
#(
   parameter int KEY_COUNT = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire map_rd_type map_rd,
   input  wire map_wr_type map_wr,
   output logic            rd_data
);

   localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W+1)'(KEY_COUNT);

   logic                 mem [KEY_COUNT];
   logic [KEY_COUNT-1:0] valid_ff;
   logic [KEY_COUNT-1:0] valid_in;
   logic                 rd_data_ff;
   logic                 rd_hit;
   logic                 wr_hit;

   assign rd_hit = ({1'b0, map_rd.addr} < KEY_LIMIT);
   assign wr_hit = map_wr.en && ({1'b0, map_wr.addr} < KEY_LIMIT);

   always_comb begin
      valid_in = valid_ff;
      if (wr_hit)
         valid_in[map_wr.addr[AW-1:0]] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (wr_hit)
         mem[map_wr.addr[AW-1:0]] <= map_wr.data;
   end

   // read before write; the controller forwards a same-cycle write
   always_ff @(posedge clock) begin
      if (map_rd.en)
         rd_data_ff <= rd_hit && valid_ff[map_rd.addr[AW-1:0]] &&
                       mem[map_rd.addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/kbsr_scan_ctl.sv
// ----------------------------------------------------------------------------
// kbsr_scan_ctl
// Sample stage: compares a sample against the down-map, translates new
// presses, fills report slots and closes the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsr_scan_ctl
   import kbsr_pkg::*;
#(
   parameter int KEY_COUNT  = 256,
   parameter int SLOT_COUNT = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire logic [1:0]       layout,
   input  wire logic             accept,
   input  wire logic             advance,
   input  wire logic [KEY_W-1:0] key_number,
   input  wire logic             key_down,
   input  wire logic [MOD_W-1:0] modifier_bits,
   input  wire logic             scan_end,
   input  wire logic             map_rd_data,
   output map_rd_type            map_rd,
   output map_wr_type            map_wr,
   output logic                  closing,
   output logic                  emit,
   output report_type            report
);

   localparam int SW = $clog2(SLOT_COUNT + 1);
   localparam logic [SW-1:0]  SLOT_LIMIT = SW'(SLOT_COUNT);
   localparam logic [KEY_W:0] KEY_LIMIT  = (KEY_W+1)'(KEY_COUNT);

   logic                     s1_valid_ff, s1_valid_in;
   logic [KEY_W-1:0]         s1_key_ff;
   logic                     s1_down_ff;
   logic [MOD_W-1:0]         s1_mods_ff;
   logic                     s1_last_ff;

   logic                     byp_valid_ff;
   logic [KEY_W-1:0]         byp_addr_ff;
   logic                     byp_data_ff;

   logic [SW-1:0]            slots_ff, slots_in, slots_inc;
   logic                     change_ff, change_in, change_tmp;
   logic [MOD_W-1:0]         prev_mods_ff, prev_mods_in;
   logic [CODE_W-1:0]        codes_ff  [SLOT_COUNT];
   logic [CODE_W-1:0]        codes_in  [SLOT_COUNT];
   logic [CODE_W-1:0]        codes_tmp [SLOT_COUNT];

   logic                     prev_bit;
   logic                     in_range;
   logic                     full;
   logic                     changed;
   logic                     take_code;
   logic                     wr_en;
   logic [CODE_W-1:0]        code;

   assign map_rd.en   = accept;
   assign map_rd.addr = key_number;

   assign s1_valid_in = advance ? (accept && enable) : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_key_ff  <= key_number;
         s1_down_ff <= key_down;
         s1_mods_ff <= modifier_bits;
         s1_last_ff <= scan_end;
      end
   end

   // the write of the previous sample lands on the same edge as this read
   assign prev_bit = (byp_valid_ff && byp_addr_ff == s1_key_ff) ? byp_data_ff
                                                                : map_rd_data;

   assign in_range  = ({1'b0, s1_key_ff} < KEY_LIMIT);
   assign full      = (slots_ff >= SLOT_LIMIT);
   assign code      = translate(layout, s1_key_ff);
   assign slots_inc = slots_ff + SW'(1);
   assign changed   = !full && in_range && (s1_down_ff != prev_bit);
   assign take_code = changed && s1_down_ff && (code != '0);
   // the press that fills the last slot is collected but not recorded
   assign wr_en     = changed && (!s1_down_ff ||
                                  (code != '0 && slots_inc < SLOT_LIMIT));

   assign change_tmp = change_ff || wr_en ||
                       (s1_last_ff && s1_mods_ff != prev_mods_ff);

   always_comb begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
         codes_tmp[j] = codes_ff[j];
         if (take_code && slots_ff == SW'(j))
            codes_tmp[j] = code;
      end
   end

   always_comb begin
      slots_in     = slots_ff;
      change_in    = change_ff;
      prev_mods_in = prev_mods_ff;
      codes_in     = codes_ff;
      if (s1_valid_ff && advance) begin
         if (s1_last_ff) begin
            slots_in     = '0;
            change_in    = 1'b0;
            prev_mods_in = s1_mods_ff;
            for (int j = 0; j < SLOT_COUNT; j++)
               codes_in[j] = '0;
         end else begin
            slots_in  = take_code ? slots_inc : slots_ff;
            change_in = change_tmp;
            codes_in  = codes_tmp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= '0;
         change_ff    <= 1'b0;
         prev_mods_ff <= '0;
         for (int j = 0; j < SLOT_COUNT; j++)
            codes_ff[j] <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         change_ff    <= change_in;
         prev_mods_ff <= prev_mods_in;
         codes_ff     <= codes_in;
         if (advance)
            byp_valid_ff <= map_wr.en;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byp_addr_ff <= s1_key_ff;
         byp_data_ff <= s1_down_ff;
      end
   end

   assign map_wr.en   = s1_valid_ff && advance && wr_en;
   assign map_wr.addr = s1_key_ff;
   assign map_wr.data = s1_down_ff;

   assign closing = s1_valid_ff && s1_last_ff;
   assign emit    = closing && change_tmp;

   always_comb begin
      report.mods = s1_mods_ff;
      for (int j = 0; j < OUT_SLOTS; j++) begin
         if (j < SLOT_COUNT)
            report.codes[j] = codes_tmp[j];
         else
            report.codes[j] = '0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/keyboard_scan_report_builder.sv
// ----------------------------------------------------------------------------
// keyboard_scan_report_builder
// Builds boot-keyboard style reports from per-key scan samples.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | beat
//  req_    | in        | req_valid/req_stall | one key sample
//  rsp_    | out       | rsp_valid/rsp_stall | one report (modifiers + 6 codes)
//  csr_    | in        | csr_valid/csr_ready | register index + data
//
//  One sample per cycle unless req_stall is high. A sample reads the down-map
//  RAM on acceptance and is resolved from the registered read, with the write
//  forwarded to the sample behind. A report leaves through an output register
//  loaded as its scan-end sample advances. req_stall rises only while a
//  scan-end sample waits behind a stalled report. On reset the map reads all up.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scan_report_builder
   import kbsr_pkg::*;
#(
   parameter int KEY_COUNT  = 256,
   parameter int SLOT_COUNT = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [KEY_W-1:0]  req_key_number,
   input  wire logic              req_key_down,
   input  wire logic [MOD_W-1:0]  req_modifier_bits,
   input  wire logic              req_scan_end,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [MOD_W-1:0]       rsp_report_modifiers,
   output logic [CODE_W-1:0]      rsp_code_slot_a,
   output logic [CODE_W-1:0]      rsp_code_slot_b,
   output logic [CODE_W-1:0]      rsp_code_slot_c,
   output logic [CODE_W-1:0]      rsp_code_slot_d,
   output logic [CODE_W-1:0]      rsp_code_slot_e,
   output logic [CODE_W-1:0]      rsp_code_slot_f,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [1:0]        csr_data
);

   logic       enable_ff, enable_in;
   logic [1:0] layout_ff, layout_in;
   logic       rsp_valid_ff, rsp_valid_in;
   report_type rsp_report_ff;

   logic       advance;
   logic       accept;
   logic       closing;
   logic       emit;
   logic       map_rd_data;
   map_rd_type map_rd;
   map_wr_type map_wr;
   report_type report;

   assign csr_ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      layout_in = layout_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE: enable_in = csr_data[0];
            CSR_LAYOUT: layout_in = csr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         layout_ff <= LAYOUT_QWERTY;
      end else begin
         enable_ff <= enable_in;
         layout_ff <= layout_in;
      end
   end

   assign advance   = !(closing && rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   kbsr_map_ram #(
      .KEY_COUNT (KEY_COUNT)
   ) u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .map_rd  (map_rd),
      .map_wr  (map_wr),
      .rd_data (map_rd_data)
   );

   kbsr_scan_ctl #(
      .KEY_COUNT  (KEY_COUNT),
      .SLOT_COUNT (SLOT_COUNT)
   ) u_scan_ctl (
      .clock         (clock),
      .reset         (reset),
      .enable        (enable_ff),
      .layout        (layout_ff),
      .accept        (accept),
      .advance       (advance),
      .key_number    (req_key_number),
      .key_down      (req_key_down),
      .modifier_bits (req_modifier_bits),
      .scan_end      (req_scan_end),
      .map_rd_data   (map_rd_data),
      .map_rd        (map_rd),
      .map_wr        (map_wr),
      .closing       (closing),
      .emit          (emit),
      .report        (report)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && emit)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance && emit)
         rsp_report_ff <= report;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_report_modifiers = rsp_report_ff.mods;
   assign rsp_code_slot_a      = rsp_report_ff.codes[0];
   assign rsp_code_slot_b      = rsp_report_ff.codes[1];
   assign rsp_code_slot_c      = rsp_report_ff.codes[2];
   assign rsp_code_slot_d      = rsp_report_ff.codes[3];
   assign rsp_code_slot_e      = rsp_report_ff.codes[4];
   assign rsp_code_slot_f      = rsp_report_ff.codes[5];

endmodule

`default_nettype wire

FILE: rtl/core/kbsr_checker.sv
// ----------------------------------------------------------------------------
// kbsr_checker
// Port-level checks for the keyboard scan report builder.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsr_checker
   import kbsr_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [CODE_W-1:0] rsp_code_slot_a,
   input wire logic [CODE_W-1:0] rsp_code_slot_b,
   input wire logic [CODE_W-1:0] rsp_code_slot_c
);

   // a report beat held by the sink stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("report dropped while stalled");

   // samples are only held back behind a stalled report
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("sample stall without a stalled report");

   // no report straight out of reset
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("report valid after reset");

   // codes fill slots in order
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_code_slot_c != '0) |->
         (rsp_code_slot_b != '0) && (rsp_code_slot_a != '0))
      else $error("report slot gap");

endmodule

bind keyboard_scan_report_builder kbsr_checker u_kbsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_code_slot_a (rsp_code_slot_a),
   .rsp_code_slot_b (rsp_code_slot_b),
   .rsp_code_slot_c (rsp_code_slot_c)
);

`default_nettype wire
